// ===== design/bpp_pkg.sv =====
// Shared constants, types and state encodings for the bitmap line and point plotter.
`default_nettype none

package bpp_pkg;

  localparam int COLS         = 40;
  localparam int ROWS         = 30;
  localparam int COL_W        = $clog2(COLS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int CRD_W        = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int D_W          = CRD_W + 3;
  localparam int FRAC_W       = 17;
  localparam int FUNC_W       = 2;
  localparam int SEL_W        = 5;
  localparam int ROW_OUT_BITS = 40;
  localparam int SHOW_BITS    = (COLS < ROW_OUT_BITS) ? COLS : ROW_OUT_BITS;

  localparam logic [FUNC_W-1:0] FUNC_PLOT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LINE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pix_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PLOT,
    ST_LSETUP,
    ST_LINE,
    ST_RREAD,
    ST_RDATA,
    ST_DRAIN,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_FIRST,
    LN_LAST,
    LN_STEP
  } line_phase_t;

endpackage

`default_nettype wire

// ===== design/bpp_pixel_ram.sv =====
// Row memory of the bitmap with per-row valid bits and a pipelined set-pixel read-modify-write.
`default_nettype none

module bpp_pixel_ram
  import bpp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pix_req_t         set_req,
  input  wire logic [ROW_W-1:0] rd_row,
  output logic      [COLS-1:0]  rd_word
);

  logic [COLS-1:0]  ram [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [COLS-1:0]  ram_q;
  logic             p_set;
  logic [ROW_W-1:0] p_row;
  logic [COL_W-1:0] p_col;
  logic             p_hit;
  logic             p_valid;
  logic [COLS-1:0]  last_w;
  logic [ROW_W-1:0] addr;
  logic [COLS-1:0]  base;
  logic [COLS-1:0]  wdata;

  assign addr    = set_req.vld ? set_req.row : rd_row;
  assign base    = p_hit ? last_w : (p_valid ? ram_q : '0);
  assign wdata   = base | (COLS'(1) << p_col);
  assign rd_word = base;

  always_ff @(posedge clk) begin
    ram_q  <= ram[addr];
    p_row  <= set_req.row;
    p_col  <= set_req.col;
    if (p_set) begin
      ram[p_row] <= wdata;
      last_w     <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      p_set     <= 1'b0;
      p_hit     <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      p_set   <= set_req.vld;
      p_hit   <= p_set && (p_row == addr);
      p_valid <= (32'(addr) < ROWS) && row_valid[addr];
      if (p_set) begin
        row_valid[p_row] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bpp_line_gen.sv =====
// Bresenham stepper that emits one pixel of a line per cycle.
`default_nettype none

module bpp_line_gen
  import bpp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [COL_W-1:0] x1,
  input  wire logic [ROW_W-1:0] y1,
  input  wire logic [COL_W-1:0] x2,
  input  wire logic [ROW_W-1:0] y2,
  output logic                  active,
  output pix_req_t              pix
);

  line_phase_t        phase;
  line_phase_t        phase_next;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [COL_W-1:0]   xe;
  logic [ROW_W-1:0]   ye;
  logic signed [D_W-1:0] d;
  logic signed [D_W-1:0] inc_diag;
  logic signed [D_W-1:0] inc_axis;
  logic               sx_neg;
  logic               sy_neg;
  logic               y_major;
  logic [CRD_W-1:0]   rem;

  logic [CRD_W-1:0]   adx;
  logic [CRD_W-1:0]   ady;
  logic               ymaj_in;
  logic [CRD_W-1:0]   major_in;
  logic [CRD_W-1:0]   minor_in;
  logic [COL_W-1:0]   x_step;
  logic [ROW_W-1:0]   y_step;
  logic [COL_W-1:0]   x_nx;
  logic [ROW_W-1:0]   y_nx;
  logic signed [D_W-1:0] d_nx;

  always_comb begin
    adx      = (x1 > x2) ? CRD_W'(x1 - x2) : CRD_W'(x2 - x1);
    ady      = (y1 > y2) ? CRD_W'(y1 - y2) : CRD_W'(y2 - y1);
    ymaj_in  = adx < ady;
    major_in = ymaj_in ? ady : adx;
    minor_in = ymaj_in ? adx : ady;

    x_step = sx_neg ? x - COL_W'(1) : x + COL_W'(1);
    y_step = sy_neg ? y - ROW_W'(1) : y + ROW_W'(1);
    if (d > 0) begin
      x_nx = x_step;
      y_nx = y_step;
      d_nx = d + inc_diag;
    end else begin
      x_nx = y_major ? x : x_step;
      y_nx = y_major ? y_step : y;
      d_nx = d + inc_axis;
    end
  end

  always_comb begin
    phase_next = phase;
    pix.vld    = 1'b0;
    pix.row    = y;
    pix.col    = x;
    case (phase)
      LN_IDLE: begin
        if (load) begin
          phase_next = LN_FIRST;
        end
      end
      LN_FIRST: begin
        pix.vld    = 1'b1;
        phase_next = LN_LAST;
      end
      LN_LAST: begin
        pix.vld    = 1'b1;
        pix.row    = ye;
        pix.col    = xe;
        phase_next = (rem == '0) ? LN_IDLE : LN_STEP;
      end
      LN_STEP: begin
        pix.vld = 1'b1;
        pix.row = y_nx;
        pix.col = x_nx;
        if (rem == CRD_W'(1)) begin
          phase_next = LN_IDLE;
        end
      end
      default: begin
        phase_next = LN_IDLE;
      end
    endcase
  end

  assign active = (phase != LN_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LN_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == LN_IDLE && load) begin
      x        <= x1;
      y        <= y1;
      xe       <= x2;
      ye       <= y2;
      sx_neg   <= x1 > x2;
      sy_neg   <= y1 > y2;
      y_major  <= ymaj_in;
      d        <= D_W'(2 * int'(minor_in) - int'(major_in));
      inc_diag <= D_W'(2 * (int'(minor_in) - int'(major_in)));
      inc_axis <= D_W'(2 * int'(minor_in));
      rem      <= (major_in == '0) ? '0 : major_in - CRD_W'(1);
    end else if (phase == LN_STEP) begin
      x   <= x_nx;
      y   <= y_nx;
      d   <= d_nx;
      rem <= rem - CRD_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/bitmap_line_point_plotter.sv =====
// Top level of the bitmap line and point plotter: command control, coordinate scaling, results.
//
//   Channel   Handshake          Fields
//   command   start / busy       func, x_start, y_start, x_end, y_end, row_select
//   result    done (one cycle)   row_bits, is_row_data
//
// A plot point passes through the scale, plot and drain states before the result,
// and a read row through the scale, row read and row data states. A draw line
// passes through the scale, line setup, line and drain states; in the line state
// the stepper sets one pixel per cycle through the row memory's read-modify-write
// pipeline. Reset clears the bitmap at once through per-row valid bits. The
// result is shown for one cycle and cannot be held off.
`default_nettype none

module bitmap_line_point_plotter
  import bpp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic [FRAC_W-1:0]       x_start,
  input  wire logic [FRAC_W-1:0]       y_start,
  input  wire logic [FRAC_W-1:0]       x_end,
  input  wire logic [FRAC_W-1:0]       y_end,
  input  wire logic [SEL_W-1:0]        row_select,
  output logic                         done,
  output logic [ROW_OUT_BITS-1:0]      row_bits,
  output logic                         is_row_data
);

  state_t              state;
  state_t              state_next;
  logic [FUNC_W-1:0]   cmd;
  logic [FRAC_W-1:0]   tx1;
  logic [FRAC_W-1:0]   ty1;
  logic [FRAC_W-1:0]   tx2;
  logic [FRAC_W-1:0]   ty2;
  logic [SEL_W-1:0]    sel;
  logic [COL_W-1:0]    px1;
  logic [ROW_W-1:0]    py1;
  logic [COL_W-1:0]    px2;
  logic [ROW_W-1:0]    py2;
  logic                gen_load;
  logic                gen_active;
  pix_req_t            gen_pix;
  pix_req_t            set_req;
  logic [COLS-1:0]     rd_word;
  logic                sel_ok;

  function automatic logic [CRD_W-1:0] scale_coord(input logic [FRAC_W-1:0] t,
                                                   input logic [CRD_W-1:0] last);
    logic [FRAC_W+CRD_W:0] prod;
    logic [FRAC_W+CRD_W:0] v;
    prod = (FRAC_W+CRD_W+1)'(t) * (FRAC_W+CRD_W+1)'(last);
    v    = (prod + (FRAC_W+CRD_W+1)'(32768)) >> 16;
    if (v > (FRAC_W+CRD_W+1)'(last)) begin
      v = (FRAC_W+CRD_W+1)'(last);
    end
    return v[CRD_W-1:0];
  endfunction

  assign sel_ok = 32'(sel) < ROWS;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_RESP);

  always_comb begin
    state_next = state;
    gen_load   = 1'b0;
    set_req    = gen_pix;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        case (cmd)
          FUNC_PLOT: state_next = ST_PLOT;
          FUNC_LINE: state_next = ST_LSETUP;
          FUNC_READ: state_next = ST_RREAD;
          default:   state_next = ST_DRAIN;
        endcase
      end
      ST_PLOT: begin
        set_req.vld = 1'b1;
        set_req.row = py1;
        set_req.col = px1;
        state_next  = ST_DRAIN;
      end
      ST_LSETUP: begin
        gen_load   = 1'b1;
        state_next = ST_LINE;
      end
      ST_LINE: begin
        if (!gen_active) begin
          state_next = ST_DRAIN;
        end
      end
      ST_RREAD: begin
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        state_next = ST_RESP;
      end
      ST_DRAIN: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd <= func;
      tx1 <= x_start;
      ty1 <= y_start;
      tx2 <= x_end;
      ty2 <= y_end;
      sel <= row_select;
    end
    if (state == ST_SCALE) begin
      px1 <= COL_W'(scale_coord(tx1, CRD_W'(COLS - 1)));
      py1 <= ROW_W'(scale_coord(ty1, CRD_W'(ROWS - 1)));
      px2 <= COL_W'(scale_coord(tx2, CRD_W'(COLS - 1)));
      py2 <= ROW_W'(scale_coord(ty2, CRD_W'(ROWS - 1)));
    end
    if (state == ST_DRAIN) begin
      row_bits    <= '0;
      is_row_data <= 1'b0;
    end
    if (state == ST_RDATA) begin
      row_bits    <= sel_ok ? ROW_OUT_BITS'(rd_word[SHOW_BITS-1:0]) : '0;
      is_row_data <= 1'b1;
    end
  end

  bpp_line_gen u_line_gen (
    .clk    (clk),
    .rst    (rst),
    .load   (gen_load),
    .x1     (px1),
    .y1     (py1),
    .x2     (px2),
    .y2     (py2),
    .active (gen_active),
    .pix    (gen_pix)
  );

  bpp_pixel_ram u_pixel_ram (
    .clk     (clk),
    .rst     (rst),
    .set_req (set_req),
    .rd_row  (ROW_W'(sel)),
    .rd_word (rd_word)
  );

endmodule

`default_nettype wire
